/* rtl/srjb_pkg.sv */
// srjb_pkg: shared types and constants for the sequence reorder jitter buffer
// used by srjb_cell, srjb_ctrl and sequence_reorder_jitter_buffer
// no dependencies

package srjb_pkg;

   // sizing
   localparam int SLOT_COUNT  = 32;
   localparam int HANDLE_BITS = 32;
   localparam int SEQ_BITS    = 16;
   localparam int PORT_HANDLE_BITS = 32;
   localparam int STORE_BITS  = (HANDLE_BITS < PORT_HANDLE_BITS) ? HANDLE_BITS
                                                                 : PORT_HANDLE_BITS;
   localparam int COUNT_BITS  = $clog2(SLOT_COUNT + 1);
   localparam int LIMIT_BITS  = 6;
   localparam int OCC_BITS    = 6;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(32);

   // request operation codes
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_DRAIN = 2'd2,
      OP_FLUSH = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_FLUSHED        = 3'd0,
      ST_STORED         = 3'd1,
      ST_REPLACED       = 3'd2,
      ST_OLDEST_DROPPED = 3'd3,
      ST_NEW_DROPPED    = 3'd4,
      ST_IN_ORDER       = 3'd5,
      ST_FORCED         = 3'd6,
      ST_NONE_READY     = 3'd7
   } status_type;

   // per-cycle operation broadcast along the cell chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_INSERT_DROP,
      CELL_REPLACE,
      CELL_REMOVE
   } cell_op_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_DROP,
      CTRL_DRAIN
   } ctrl_state_type;

   typedef struct packed {
      cell_op_type           op;
      logic [SEQ_BITS-1:0]   key_seq;
      logic [STORE_BITS-1:0] key_handle;
   } cell_cmd_type;

   // what the controller sees of the chain
   typedef struct packed {
      logic [SEQ_BITS-1:0]   head_seq;
      logic [STORE_BITS-1:0] head_handle;
      logic                  lt_head;
      logic                  eq_head;
      logic                  eq_any;
   } chain_status_type;

endpackage

/* rtl/srjb_cell.sv */
// srjb_cell: one slot of the sorted chain, holds a sequence number and handle
// compares against the broadcast key and trades entries with its neighbors
// depends on srjb_pkg

module srjb_cell
   import srjb_pkg::*;
(
   input  logic                  clock,
   input  cell_cmd_type          cmd,
   input  logic                  occupied,
   input  logic                  left_lt,
   input  logic [SEQ_BITS-1:0]   left_seq,
   input  logic [STORE_BITS-1:0] left_handle,
   input  logic                  right_lt,
   input  logic [SEQ_BITS-1:0]   right_seq,
   input  logic [STORE_BITS-1:0] right_handle,
   output logic [SEQ_BITS-1:0]   seq,
   output logic [STORE_BITS-1:0] handle,
   output logic                  lt,
   output logic                  eq
);

   logic [SEQ_BITS-1:0]   seq_ff, seq_in;
   logic [STORE_BITS-1:0] handle_ff, handle_in;

   // key compare, only meaningful for occupied slots
   assign lt = occupied && (seq_ff < cmd.key_seq);
   assign eq = occupied && (seq_ff == cmd.key_seq);

   // slot update
   always_comb begin
      seq_in    = seq_ff;
      handle_in = handle_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (!lt) begin
               if (left_lt) begin
                  seq_in    = cmd.key_seq;
                  handle_in = cmd.key_handle;
               end else begin
                  seq_in    = left_seq;
                  handle_in = left_handle;
               end
            end
         end
         CELL_INSERT_DROP: begin
            if (right_lt) begin
               seq_in    = right_seq;
               handle_in = right_handle;
            end else if (lt) begin
               seq_in    = cmd.key_seq;
               handle_in = cmd.key_handle;
            end
         end
         CELL_REPLACE: begin
            if (eq) begin
               handle_in = cmd.key_handle;
            end
         end
         CELL_REMOVE: begin
            seq_in    = right_seq;
            handle_in = right_handle;
         end
         default: begin
            seq_in    = seq_ff;
            handle_in = handle_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      seq_ff    <= seq_in;
      handle_ff <= handle_in;
   end

   assign seq    = seq_ff;
   assign handle = handle_ff;

endmodule

/* rtl/srjb_ctrl.sv */
// srjb_ctrl: operation sequencer, occupancy, release tracking and result registers
// drives the command broadcast to the cell chain
// depends on srjb_pkg

module srjb_ctrl
   import srjb_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_operation,
   input  logic [SEQ_BITS-1:0]         req_sequence_number,
   input  logic [PORT_HANDLE_BITS-1:0] req_payload_handle,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [LIMIT_BITS-1:0]       csr_packet_limit,
   input  chain_status_type            chain,
   output cell_cmd_type                cmd,
   output logic [COUNT_BITS-1:0]       count,
   output logic                        rsp_strobe,
   output logic                        rsp_packet_valid,
   output logic [SEQ_BITS-1:0]         rsp_released_sequence,
   output logic [PORT_HANDLE_BITS-1:0] rsp_released_handle,
   output logic [2:0]                  rsp_status,
   output logic [OCC_BITS-1:0]         rsp_occupancy,
   output logic                        rsp_last_result
);

   ctrl_state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SEQ_BITS-1:0]   last_seq_ff, last_seq_in;
   logic                  awaiting_ff, awaiting_in;
   logic [LIMIT_BITS-1:0] limit_ff;
   status_type            drop_status_ff, drop_status_in;

   // drain holds one release back until it knows whether another follows
   logic [SEQ_BITS-1:0]   pend_seq_ff, pend_seq_in;
   logic [STORE_BITS-1:0] pend_handle_ff, pend_handle_in;
   status_type            pend_status_ff, pend_status_in;
   logic [COUNT_BITS-1:0] pend_occ_ff, pend_occ_in;

   logic                  strobe_ff, strobe_in;
   logic                  valid_ff, valid_in;
   logic [SEQ_BITS-1:0]   rseq_ff, rseq_in;
   logic [STORE_BITS-1:0] rhandle_ff, rhandle_in;
   status_type            status_ff, status_in;
   logic [COUNT_BITS-1:0] occ_ff, occ_in;
   logic                  last_ff, last_in;

   logic                  accept;
   op_type                op;
   logic [COUNT_BITS-1:0] eff_limit;
   logic                  nonempty;
   logic [SEQ_BITS-1:0]   expected;
   logic                  in_order;
   logic                  forced;
   logic                  release_head;
   status_type            pop_status;
   logic [COUNT_BITS-1:0] count_dec;

   assign accept    = start && (state_ff == CTRL_IDLE);
   assign op        = op_type'(req_operation);
   assign busy      = (state_ff != CTRL_IDLE);
   // no limit write in the cycle a request is taken
   assign csr_ready = (state_ff == CTRL_IDLE) && !start;

   // limit above the slot count acts as the slot count
   always_comb begin
      if (int'(limit_ff) > SLOT_COUNT) begin
         eff_limit = COUNT_BITS'(SLOT_COUNT);
      end else begin
         eff_limit = COUNT_BITS'(limit_ff);
      end
   end

   // pop decision on the head slot
   assign nonempty     = (count_ff != '0);
   assign expected     = awaiting_ff ? chain.head_seq : last_seq_ff + SEQ_BITS'(1);
   assign in_order     = nonempty && (chain.head_seq == expected);
   assign forced       = nonempty && !in_order && (count_ff > (eff_limit >> 1));
   assign release_head = in_order || forced;
   assign pop_status   = in_order ? ST_IN_ORDER : ST_FORCED;
   assign count_dec    = count_ff - COUNT_BITS'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTRL_IDLE: begin
            if (accept && op == OP_PUSH && chain.eq_any && count_ff > eff_limit) begin
               state_in = CTRL_DROP;
            end else if (accept && op == OP_DRAIN && release_head) begin
               state_in = CTRL_DRAIN;
            end
         end
         CTRL_DROP: begin
            state_in = CTRL_IDLE;
         end
         CTRL_DRAIN: begin
            if (!release_head) begin
               state_in = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   // chain command, bookkeeping and result values
   always_comb begin
      cmd.op         = CELL_HOLD;
      cmd.key_seq    = req_sequence_number;
      cmd.key_handle = STORE_BITS'(req_payload_handle);
      count_in       = count_ff;
      last_seq_in    = last_seq_ff;
      awaiting_in    = awaiting_ff;
      drop_status_in = drop_status_ff;
      pend_seq_in    = pend_seq_ff;
      pend_handle_in = pend_handle_ff;
      pend_status_in = pend_status_ff;
      pend_occ_in    = pend_occ_ff;
      strobe_in      = 1'b0;
      valid_in       = 1'b0;
      rseq_in        = '0;
      rhandle_in     = '0;
      status_in      = ST_NONE_READY;
      occ_in         = count_ff;
      last_in        = 1'b1;
      case (state_ff)
         CTRL_IDLE: begin
            if (accept) begin
               case (op)
                  OP_PUSH: begin
                     if (chain.eq_any) begin
                        cmd.op = CELL_REPLACE;
                        if (count_ff > eff_limit) begin
                           drop_status_in = chain.eq_head ? ST_NEW_DROPPED
                                                          : ST_OLDEST_DROPPED;
                        end else begin
                           strobe_in = 1'b1;
                           status_in = ST_REPLACED;
                        end
                     end else if (count_ff >= eff_limit) begin
                        // insert and drop the smallest in one shift
                        cmd.op    = CELL_INSERT_DROP;
                        strobe_in = 1'b1;
                        status_in = chain.lt_head ? ST_OLDEST_DROPPED : ST_NEW_DROPPED;
                     end else begin
                        cmd.op    = CELL_INSERT;
                        count_in  = count_ff + COUNT_BITS'(1);
                        strobe_in = 1'b1;
                        status_in = ST_STORED;
                        occ_in    = count_ff + COUNT_BITS'(1);
                     end
                  end
                  OP_POP: begin
                     strobe_in = 1'b1;
                     if (nonempty) begin
                        awaiting_in = 1'b0;
                     end
                     if (release_head) begin
                        cmd.op      = CELL_REMOVE;
                        count_in    = count_dec;
                        last_seq_in = chain.head_seq;
                        valid_in    = 1'b1;
                        rseq_in     = chain.head_seq;
                        rhandle_in  = chain.head_handle;
                        status_in   = pop_status;
                        occ_in      = count_dec;
                     end
                  end
                  OP_DRAIN: begin
                     if (nonempty) begin
                        awaiting_in = 1'b0;
                     end
                     if (release_head) begin
                        cmd.op         = CELL_REMOVE;
                        count_in       = count_dec;
                        last_seq_in    = chain.head_seq;
                        pend_seq_in    = chain.head_seq;
                        pend_handle_in = chain.head_handle;
                        pend_status_in = pop_status;
                        pend_occ_in    = count_dec;
                     end else begin
                        strobe_in = 1'b1;
                     end
                  end
                  OP_FLUSH: begin
                     count_in    = '0;
                     awaiting_in = 1'b1;
                     strobe_in   = 1'b1;
                     status_in   = ST_FLUSHED;
                     occ_in      = '0;
                  end
                  default: begin
                     cmd.op = CELL_HOLD;
                  end
               endcase
            end
         end
         CTRL_DROP: begin
            cmd.op    = CELL_REMOVE;
            count_in  = count_dec;
            strobe_in = 1'b1;
            status_in = drop_status_ff;
            occ_in    = count_dec;
         end
         CTRL_DRAIN: begin
            // show the held release, then take the next one if any
            strobe_in  = 1'b1;
            valid_in   = 1'b1;
            rseq_in    = pend_seq_ff;
            rhandle_in = pend_handle_ff;
            status_in  = pend_status_ff;
            occ_in     = pend_occ_ff;
            last_in    = !release_head;
            if (release_head) begin
               cmd.op         = CELL_REMOVE;
               count_in       = count_dec;
               last_seq_in    = chain.head_seq;
               pend_seq_in    = chain.head_seq;
               pend_handle_in = chain.head_handle;
               pend_status_in = pop_status;
               pend_occ_in    = count_dec;
            end
         end
         default: begin
            cmd.op = CELL_HOLD;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= CTRL_IDLE;
         count_ff    <= '0;
         last_seq_ff <= '0;
         awaiting_ff <= 1'b1;
         limit_ff    <= LIMIT_RESET;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         last_seq_ff <= last_seq_in;
         awaiting_ff <= awaiting_in;
         strobe_ff   <= strobe_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_packet_limit;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      drop_status_ff <= drop_status_in;
      pend_seq_ff    <= pend_seq_in;
      pend_handle_ff <= pend_handle_in;
      pend_status_ff <= pend_status_in;
      pend_occ_ff    <= pend_occ_in;
      valid_ff       <= valid_in;
      rseq_ff        <= rseq_in;
      rhandle_ff     <= rhandle_in;
      status_ff      <= status_in;
      occ_ff         <= occ_in;
      last_ff        <= last_in;
   end

   assign count                 = count_ff;
   assign rsp_strobe            = strobe_ff;
   assign rsp_packet_valid      = valid_ff;
   assign rsp_released_sequence = rseq_ff;
   assign rsp_released_handle   = PORT_HANDLE_BITS'(rhandle_ff);
   assign rsp_status            = status_ff;
   assign rsp_occupancy         = OCC_BITS'(occ_ff);
   assign rsp_last_result       = last_ff;

   // occupancy never passes the number of slots
   assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= SLOT_COUNT)
      else $error("occupancy above slot count");

   // a drain only continues after the first release has been synchronized
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTRL_DRAIN) |-> !awaiting_ff)
      else $error("drain while awaiting first release");

   // flush empties the chain
   assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_FLUSH) |=> (count_ff == '0 && awaiting_ff))
      else $error("flush did not empty the buffer");

   // a released packet is always in order or forced
   assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && valid_ff) |-> (status_ff == ST_IN_ORDER || status_ff == ST_FORCED))
      else $error("release with wrong status");

   // the deferred drop always ends in a result the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTRL_DROP) |=> (strobe_ff && state_ff == CTRL_IDLE))
      else $error("deferred drop lost its result");

endmodule

/* rtl/sequence_reorder_jitter_buffer.sv */
// sequence_reorder_jitter_buffer: top level, a sorted chain of slot cells
// under one sequencer
// depends on srjb_pkg, srjb_cell, srjb_ctrl

// Holds up to 32 packets sorted by 16-bit sequence number (plain unsigned
// compare, no wrap handling) in a chain of cells, each a slot that compares
// itself against the broadcast key and shifts together with its neighbors.
// An item is taken when start is high and busy is low. Push, pop and flush
// give one result in the cycle after they are taken; a replace that has to
// drop the smallest entry first goes through the drop state. Drain gives one
// result per released packet, one per cycle, or one none-ready result if none,
// with last_result on the final one, and busy stays high until it is done.
// The receiver cannot stall: every result is on the rsp_ ports for exactly
// the one cycle that rsp_strobe is high. The packet limit is written through
// the csr_ port while busy and start are both low; values above 32 act as 32.

module sequence_reorder_jitter_buffer
   import srjb_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_operation,
   input  logic [SEQ_BITS-1:0]         req_sequence_number,
   input  logic [PORT_HANDLE_BITS-1:0] req_payload_handle,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [LIMIT_BITS-1:0]       csr_packet_limit,
   output logic                        rsp_strobe,
   output logic                        rsp_packet_valid,
   output logic [SEQ_BITS-1:0]         rsp_released_sequence,
   output logic [PORT_HANDLE_BITS-1:0] rsp_released_handle,
   output logic [2:0]                  rsp_status,
   output logic [OCC_BITS-1:0]         rsp_occupancy,
   output logic                        rsp_last_result
);

   cell_cmd_type          cmd;
   chain_status_type      chain;
   logic [COUNT_BITS-1:0] count;

   logic [SEQ_BITS-1:0]   cell_seq    [SLOT_COUNT];
   logic [STORE_BITS-1:0] cell_handle [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] cell_lt;
   logic [SLOT_COUNT-1:0] cell_eq;

   // chain of slots, smallest at index zero
   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      logic                  left_lt, right_lt;
      logic [SEQ_BITS-1:0]   left_seq, right_seq;
      logic [STORE_BITS-1:0] left_handle, right_handle;

      if (i == 0) begin : g_first
         assign left_lt     = 1'b1;
         assign left_seq    = cmd.key_seq;
         assign left_handle = cmd.key_handle;
      end else begin : g_inner_left
         assign left_lt     = cell_lt[i-1];
         assign left_seq    = cell_seq[i-1];
         assign left_handle = cell_handle[i-1];
      end

      if (i == SLOT_COUNT - 1) begin : g_last
         assign right_lt     = 1'b0;
         assign right_seq    = '0;
         assign right_handle = '0;
      end else begin : g_inner_right
         assign right_lt     = cell_lt[i+1];
         assign right_seq    = cell_seq[i+1];
         assign right_handle = cell_handle[i+1];
      end

      srjb_cell u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .occupied     (COUNT_BITS'(i) < count),
         .left_lt      (left_lt),
         .left_seq     (left_seq),
         .left_handle  (left_handle),
         .right_lt     (right_lt),
         .right_seq    (right_seq),
         .right_handle (right_handle),
         .seq          (cell_seq[i]),
         .handle       (cell_handle[i]),
         .lt           (cell_lt[i]),
         .eq           (cell_eq[i])
      );
   end

   // head slot and match summary for the sequencer
   assign chain.head_seq    = cell_seq[0];
   assign chain.head_handle = cell_handle[0];
   assign chain.lt_head     = cell_lt[0];
   assign chain.eq_head     = cell_eq[0];
   assign chain.eq_any      = |cell_eq;

   srjb_ctrl u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_operation         (req_operation),
      .req_sequence_number   (req_sequence_number),
      .req_payload_handle    (req_payload_handle),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_packet_limit      (csr_packet_limit),
      .chain                 (chain),
      .cmd                   (cmd),
      .count                 (count),
      .rsp_strobe            (rsp_strobe),
      .rsp_packet_valid      (rsp_packet_valid),
      .rsp_released_sequence (rsp_released_sequence),
      .rsp_released_handle   (rsp_released_handle),
      .rsp_status            (rsp_status),
      .rsp_occupancy         (rsp_occupancy),
      .rsp_last_result       (rsp_last_result)
   );

endmodule

/* bench/srjb_release_checker.sv */
// srjb_release_checker: watches the request, response and csr channels of the
// jitter buffer, predicts every response and compares it in arrival order
// depends on srjb_pkg
`timescale 1ns / 1ps

module srjb_release_checker
   import srjb_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [1:0]                  req_operation,
   input  logic [SEQ_BITS-1:0]         req_sequence_number,
   input  logic [PORT_HANDLE_BITS-1:0] req_payload_handle,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [LIMIT_BITS-1:0]       csr_packet_limit,
   input  logic                        rsp_strobe,
   input  logic                        rsp_packet_valid,
   input  logic [SEQ_BITS-1:0]         rsp_released_sequence,
   input  logic [PORT_HANDLE_BITS-1:0] rsp_released_handle,
   input  logic [2:0]                  rsp_status,
   input  logic [OCC_BITS-1:0]         rsp_occupancy,
   input  logic                        rsp_last_result,
   output int                          mismatch_count,
   output int                          awaited_count
);

   typedef struct packed {
      logic                        packet_valid;
      logic [SEQ_BITS-1:0]         released_sequence;
      logic [PORT_HANDLE_BITS-1:0] released_handle;
      status_type                  status;
      logic [OCC_BITS-1:0]         occupancy;
      logic                        last_result;
   } outcome_type;

   // sorted packet store, one staging entry past the end for overflow
   logic [SEQ_BITS-1:0]         held_seq    [0:SLOT_COUNT];
   logic [PORT_HANDLE_BITS-1:0] held_handle [0:SLOT_COUNT];
   int unsigned                 held_count;
   logic [SEQ_BITS-1:0]         last_released;
   bit                          awaiting_first;
   logic [LIMIT_BITS-1:0]       limit_setting;

   outcome_type awaited_outcomes[$];

   function automatic int unsigned active_limit();
      return (limit_setting > SLOT_COUNT) ? SLOT_COUNT : int'(limit_setting);
   endfunction

   // add one predicted response at the tail
   function automatic void append_outcome(input outcome_type o);
      awaited_outcomes = {awaited_outcomes, o};
   endfunction

   function automatic outcome_type make_outcome(input logic valid,
                                                input logic [SEQ_BITS-1:0] seq,
                                                input logic [PORT_HANDLE_BITS-1:0] hnd,
                                                input status_type st,
                                                input logic last);
      outcome_type o;
      o.packet_valid      = valid;
      o.released_sequence = seq;
      o.released_handle   = hnd;
      o.status            = st;
      o.occupancy         = OCC_BITS'(held_count);
      o.last_result       = last;
      return o;
   endfunction

   function automatic string describe(input outcome_type o);
      return $sformatf("valid=%0d seq=%0d handle=%h status=%0d occ=%0d last=%0d",
                       o.packet_valid, o.released_sequence, o.released_handle,
                       o.status, o.occupancy, o.last_result);
   endfunction

   task automatic drop_head();
      int unsigned idx;
      for (idx = 1; idx < held_count; idx++) begin
         held_seq[idx-1]    = held_seq[idx];
         held_handle[idx-1] = held_handle[idx];
      end
      if (held_count > 0) held_count--;
   endtask

   // sorted insert or replace, then trim the smallest if over the limit
   task automatic store_packet(input logic [SEQ_BITS-1:0] seq,
                               input logic [PORT_HANDLE_BITS-1:0] hnd,
                               output status_type st);
      int unsigned pos;
      int unsigned idx;
      logic [SEQ_BITS-1:0] smallest;
      pos = 0;
      while (pos < held_count && held_seq[pos] < seq) pos++;
      if (pos < held_count && held_seq[pos] == seq) begin
         held_handle[pos] = hnd;
         st = ST_REPLACED;
      end else begin
         if (held_count > SLOT_COUNT) held_count = SLOT_COUNT;
         for (idx = held_count; idx > pos; idx--) begin
            held_seq[idx]    = held_seq[idx-1];
            held_handle[idx] = held_handle[idx-1];
         end
         held_seq[pos]    = seq;
         held_handle[pos] = hnd;
         held_count++;
         st = ST_STORED;
      end
      if (held_count > active_limit()) begin
         smallest = held_seq[0];
         drop_head();
         st = (smallest == seq) ? ST_NEW_DROPPED : ST_OLDEST_DROPPED;
      end
   endtask

   // release the head if it is next in line, or by force when crowded
   task automatic release_head(output logic [SEQ_BITS-1:0] seq,
                               output logic [PORT_HANDLE_BITS-1:0] hnd,
                               output status_type st);
      logic [SEQ_BITS-1:0] wanted;
      seq = '0;
      hnd = '0;
      st  = ST_NONE_READY;
      if (held_count != 0) begin
         if (awaiting_first) begin
            last_released  = held_seq[0] - 1'b1;
            awaiting_first = 1'b0;
         end
         wanted = last_released + 1'b1;
         if (held_seq[0] == wanted) begin
            seq = held_seq[0];
            hnd = held_handle[0];
            last_released = wanted;
            drop_head();
            st = ST_IN_ORDER;
         end else if (held_count > active_limit() / 2) begin
            seq = held_seq[0];
            hnd = held_handle[0];
            last_released = held_seq[0];
            drop_head();
            st = ST_FORCED;
         end
      end
   endtask

   // all responses one accepted request causes, in order
   task automatic predict_request(input op_type op,
                                  input logic [SEQ_BITS-1:0] seq,
                                  input logic [PORT_HANDLE_BITS-1:0] hnd);
      status_type                  st;
      logic [SEQ_BITS-1:0]         out_seq;
      logic [PORT_HANDLE_BITS-1:0] out_hnd;
      outcome_type                 held_back;
      bit                          have_held;
      int unsigned                 released;
      case (op)
         OP_PUSH: begin
            store_packet(seq, PORT_HANDLE_BITS'(hnd[STORE_BITS-1:0]), st);
            append_outcome(make_outcome(1'b0, '0, '0, st, 1'b1));
         end
         OP_POP: begin
            release_head(out_seq, out_hnd, st);
            append_outcome(make_outcome(st != ST_NONE_READY, out_seq,
                                        out_hnd, st, 1'b1));
         end
         OP_DRAIN: begin
            have_held = 1'b0;
            released  = 0;
            while (released < SLOT_COUNT) begin
               release_head(out_seq, out_hnd, st);
               if (st == ST_NONE_READY) break;
               if (have_held) append_outcome(held_back);
               held_back = make_outcome(1'b1, out_seq, out_hnd, st, held_count == 0);
               have_held = 1'b1;
               released++;
            end
            if (have_held) begin
               held_back.last_result = 1'b1;
               append_outcome(held_back);
            end else begin
               append_outcome(make_outcome(1'b0, '0, '0, ST_NONE_READY, 1'b1));
            end
         end
         default: begin
            held_count     = 0;
            awaiting_first = 1'b1;
            append_outcome(make_outcome(1'b0, '0, '0, ST_FLUSHED, 1'b1));
         end
      endcase
   endtask

   // compare responses, track the limit register, predict accepted requests
   always @(posedge clock) begin
      outcome_type seen;
      outcome_type wanted;
      if (reset) begin
         held_count     = 0;
         last_released  = '0;
         awaiting_first = 1'b1;
         limit_setting  = LIMIT_RESET;
         mismatch_count = 0;
         awaited_outcomes.delete();
      end else begin
         if (rsp_strobe) begin
            seen.packet_valid      = rsp_packet_valid;
            seen.released_sequence = rsp_released_sequence;
            seen.released_handle   = rsp_released_handle;
            seen.status            = status_type'(rsp_status);
            seen.occupancy         = rsp_occupancy;
            seen.last_result       = rsp_last_result;
            if (awaited_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("[%0t] response with none pending: %s", $realtime,
                           describe(seen));
            end else begin
               wanted = awaited_outcomes.pop_front();
               if (seen.packet_valid !== wanted.packet_valid ||
                   seen.released_sequence !== wanted.released_sequence ||
                   seen.released_handle !== wanted.released_handle ||
                   seen.status !== wanted.status ||
                   seen.occupancy !== wanted.occupancy ||
                   seen.last_result !== wanted.last_result) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("[%0t] response mismatch", $realtime);
                     $display("   expected %s", describe(wanted));
                     $display("   actual   %s", describe(seen));
                  end
               end
            end
         end
         if (csr_valid && csr_ready) limit_setting = csr_packet_limit;
         if (start && !busy)
            predict_request(op_type'(req_operation), req_sequence_number,
                            req_payload_handle);
      end
      awaited_count = awaited_outcomes.size();
   end

endmodule

/* bench/testbench.sv */
// testbench: stimulus and verdict for sequence_reorder_jitter_buffer
// depends on srjb_pkg, the block under test and srjb_release_checker
`timescale 1ns / 1ps

module testbench
   import srjb_pkg::*;
;

   localparam int CYCLE_LIMIT = 300000;
   localparam int TAIL_CYCLES = 40;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [1:0]                  req_operation;
   logic [SEQ_BITS-1:0]         req_sequence_number;
   logic [PORT_HANDLE_BITS-1:0] req_payload_handle;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [LIMIT_BITS-1:0]       csr_packet_limit;
   logic                        rsp_strobe;
   logic                        rsp_packet_valid;
   logic [SEQ_BITS-1:0]         rsp_released_sequence;
   logic [PORT_HANDLE_BITS-1:0] rsp_released_handle;
   logic [2:0]                  rsp_status;
   logic [OCC_BITS-1:0]         rsp_occupancy;
   logic                        rsp_last_result;
   int                          mismatch_count;
   int                          awaited_count;
   int                          cycle_count;

   sequence_reorder_jitter_buffer i_dut (.*);

   srjb_release_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop if the run hangs
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // present one request and hold it until the transfer
   task automatic offer_item(input op_type op, input logic [SEQ_BITS-1:0] seq,
                             input logic [PORT_HANDLE_BITS-1:0] hnd);
      @(negedge clock);
      start               <= 1'b1;
      req_operation       <= op;
      req_sequence_number <= seq;
      req_payload_handle  <= hnd;
      do @(posedge clock); while (busy);
   endtask

   task automatic rest(input int unsigned cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // stop sending and wait for every predicted response
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
      settle();
      @(negedge clock);
      csr_valid        <= 1'b1;
      csr_packet_limit <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // extremes, every operation and the corner cases in a fixed order
   task automatic run_directed();
      offer_item(OP_POP, 16'h0000, 32'h0000_0000);      // empty buffer, flag stays set
      offer_item(OP_DRAIN, 16'hFFFF, 32'hFFFF_FFFF);    // nothing to drain
      offer_item(OP_PUSH, 16'h0000, 32'h0000_0000);
      offer_item(OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
      offer_item(OP_PUSH, 16'd100, 32'hA5A5_A5A5);
      offer_item(OP_PUSH, 16'd100, 32'h5A5A_5A5A);      // replace
      offer_item(OP_PUSH, 16'd5, $urandom);
      offer_item(OP_PUSH, 16'd7, $urandom);
      offer_item(OP_PUSH, 16'd6, $urandom);
      offer_item(OP_POP, SEQ_BITS'($urandom), $urandom);   // first pop adopts the head
      offer_item(OP_POP, SEQ_BITS'($urandom), $urandom);   // gap, nothing ready
      offer_item(OP_DRAIN, SEQ_BITS'($urandom), $urandom);
      // lowered limit: replace while already over it
      write_limit(6'd2);
      offer_item(OP_PUSH, 16'd7, $urandom);
      offer_item(OP_PUSH, 16'd6, $urandom);
      offer_item(OP_POP, SEQ_BITS'($urandom), $urandom);   // forced release
      offer_item(OP_DRAIN, SEQ_BITS'($urandom), $urandom);
      // zero limit drops on every push
      write_limit(6'd0);
      offer_item(OP_PUSH, 16'd300, $urandom);
      offer_item(OP_PUSH, 16'hFFFF, $urandom);
      offer_item(OP_PUSH, 16'd40000, $urandom);
      offer_item(OP_POP, SEQ_BITS'($urandom), $urandom);
      // limit beyond the store size, and the expected number wrapping
      write_limit(6'd63);
      offer_item(OP_FLUSH, SEQ_BITS'($urandom), $urandom);
      offer_item(OP_PUSH, 16'hFFFF, $urandom);
      offer_item(OP_POP, SEQ_BITS'($urandom), $urandom);
      offer_item(OP_PUSH, 16'h0000, $urandom);
      offer_item(OP_POP, SEQ_BITS'($urandom), $urandom);
      offer_item(OP_PUSH, 16'd2, $urandom);
      offer_item(OP_PUSH, 16'd1, $urandom);
      offer_item(OP_PUSH, 16'd3, $urandom);
      offer_item(OP_DRAIN, SEQ_BITS'($urandom), $urandom);
   endtask

   // mostly a stream of nearby numbers with some reordering, plus noise
   task automatic run_traffic(input int unsigned items, input int unsigned idle_pct,
                              input logic [SEQ_BITS-1:0] first_seq);
      logic [SEQ_BITS-1:0] next_seq;
      logic [SEQ_BITS-1:0] seq;
      int unsigned         pick;
      int unsigned         style;
      next_seq = first_seq;
      repeat (items) begin
         pick = $urandom_range(0, 99);
         if (pick < 52) begin
            style = $urandom_range(0, 9);
            if (style < 5) begin
               seq      = next_seq;
               next_seq = next_seq + 1'b1;
            end else if (style < 8) begin
               seq = next_seq + SEQ_BITS'($urandom_range(1, 8));
            end else begin
               seq = next_seq - SEQ_BITS'($urandom_range(0, 3));
            end
            offer_item(OP_PUSH, seq, $urandom);
         end else if (pick < 57) begin
            offer_item(OP_PUSH, SEQ_BITS'($urandom), $urandom);
         end else if (pick < 82) begin
            offer_item(OP_POP, SEQ_BITS'($urandom), $urandom);
         end else if (pick < 95) begin
            offer_item(OP_DRAIN, SEQ_BITS'($urandom), $urandom);
         end else begin
            offer_item(OP_FLUSH, SEQ_BITS'($urandom), $urandom);
         end
         if ($urandom_range(0, 99) < idle_pct) rest($urandom_range(1, 5));
         if ($urandom_range(0, 39) == 0) next_seq = SEQ_BITS'($urandom);
      end
   endtask

   // the receiver has no stall input, so only the sender idles
   initial begin
      reset               <= 1'b1;
      start               <= 1'b0;
      req_operation       <= OP_PUSH;
      req_sequence_number <= '0;
      req_payload_handle  <= '0;
      csr_valid           <= 1'b0;
      csr_packet_limit    <= '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      run_directed();

      write_limit(6'd32);
      run_traffic(55, 0, 16'hFFF0);
      write_limit(6'd5);
      run_traffic(45, 52, SEQ_BITS'($urandom));
      write_limit(6'd1);
      run_traffic(35, 0, SEQ_BITS'($urandom));
      write_limit(6'd12);
      run_traffic(55, 8, SEQ_BITS'($urandom));
      write_limit(6'd0);
      run_traffic(25, 52, SEQ_BITS'($urandom));
      write_limit(6'd63);
      run_traffic(65, 8, SEQ_BITS'($urandom));

      settle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
